>>> rtl/npl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the multiply schedule for the nearest point to line search.
// No dependencies.
package npl_pkg;

  localparam int unsigned COORD_W   = 14;
  localparam int unsigned LIMIT_W   = 13;
  localparam int unsigned INDEX_W   = 12;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned CROSS_W   = 2 * COORD_W + 2;
  localparam int unsigned LIM2_W    = 2 * LIMIT_W;
  localparam int unsigned AB2_W     = 2 * DIFF_W;
  localparam int unsigned MUL_W     = CROSS_W + 1;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned SQ_W      = 60;

  localparam int unsigned MAX_POINTS_DEF = 4096;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_NEAR_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FAR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FAR_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DIST = 3'd6;

  localparam logic [LIMIT_W-1:0] MAX_DIST_RST = 13'd640;

  localparam int unsigned NUM_STEPS = 14;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS + 1);
  localparam logic [STEP_W-1:0] STEP_DRAIN = STEP_W'(NUM_STEPS);

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic signed [COORD_W-1:0] near_z;
    logic signed [COORD_W-1:0] far_x;
    logic signed [COORD_W-1:0] far_y;
    logic signed [COORD_W-1:0] far_z;
    logic [LIMIT_W-1:0]        max_distance;
  } line_cfg_t;

  typedef enum logic [3:0] {
    OPND_ABX, OPND_ABY, OPND_ABZ,
    OPND_APX, OPND_APY, OPND_APZ,
    OPND_LIM, OPND_LIM2, OPND_AB2,
    OPND_CX, OPND_CY, OPND_CZ
  } opnd_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_CX, DST_CY, DST_CZ, DST_AB2, DST_LIM2, DST_MIN
  } dst_e;

  typedef struct packed {
    opnd_e   a;
    opnd_e   b;
    acc_op_e acc;
    dst_e    dst;
  } mul_cmd_t;

  typedef struct packed {
    logic     start;
    logic     update;
    logic     emit;
    mul_cmd_t mul;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  localparam mul_cmd_t MUL_NOP = '{a: OPND_ABX, b: OPND_ABX, acc: ACC_HOLD, dst: DST_NONE};

  // Limit squared, |AB|^2, cross components, limit reload, |AP x AB|^2
  function automatic mul_cmd_t step_cmd(input logic [STEP_W-1:0] step);
    mul_cmd_t c;
    c = MUL_NOP;
    unique case (step)
      4'd0:    c = '{a: OPND_LIM,  b: OPND_LIM,  acc: ACC_LOAD, dst: DST_LIM2};
      4'd1:    c = '{a: OPND_ABX,  b: OPND_ABX,  acc: ACC_LOAD, dst: DST_NONE};
      4'd2:    c = '{a: OPND_ABY,  b: OPND_ABY,  acc: ACC_ADD,  dst: DST_NONE};
      4'd3:    c = '{a: OPND_ABZ,  b: OPND_ABZ,  acc: ACC_ADD,  dst: DST_AB2};
      4'd4:    c = '{a: OPND_APY,  b: OPND_ABZ,  acc: ACC_LOAD, dst: DST_NONE};
      4'd5:    c = '{a: OPND_APZ,  b: OPND_ABY,  acc: ACC_SUB,  dst: DST_CX};
      4'd6:    c = '{a: OPND_APZ,  b: OPND_ABX,  acc: ACC_LOAD, dst: DST_NONE};
      4'd7:    c = '{a: OPND_APX,  b: OPND_ABZ,  acc: ACC_SUB,  dst: DST_CY};
      4'd8:    c = '{a: OPND_APX,  b: OPND_ABY,  acc: ACC_LOAD, dst: DST_NONE};
      4'd9:    c = '{a: OPND_APY,  b: OPND_ABX,  acc: ACC_SUB,  dst: DST_CZ};
      4'd10:   c = '{a: OPND_LIM2, b: OPND_AB2,  acc: ACC_LOAD, dst: DST_MIN};
      4'd11:   c = '{a: OPND_CX,   b: OPND_CX,   acc: ACC_LOAD, dst: DST_NONE};
      4'd12:   c = '{a: OPND_CY,   b: OPND_CY,   acc: ACC_ADD,  dst: DST_NONE};
      4'd13:   c = '{a: OPND_CZ,   b: OPND_CZ,   acc: ACC_ADD,  dst: DST_NONE};
      default: c = MUL_NOP;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/npl_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers: line end points and distance limit.
// Depends on npl_pkg.
module npl_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [npl_pkg::PADDR_W-1:0]       paddr,
  input  logic [npl_pkg::PDATA_W-1:0]       pwdata,
  output logic [npl_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  output npl_pkg::line_cfg_t                cfg_o
);

  npl_pkg::line_cfg_t                cfg_q;
  logic [npl_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr_en;
  logic [npl_pkg::COORD_W-1:0]       wr_coord;
  logic [npl_pkg::LIMIT_W-1:0]       wr_limit;

  assign pready   = 1'b1;
  assign idx      = paddr[npl_pkg::PADDR_W-1:2];
  assign wr_en    = psel & penable & pwrite & pready;
  assign wr_coord = pwdata[npl_pkg::COORD_W-1:0];
  assign wr_limit = pwdata[npl_pkg::LIMIT_W-1:0];
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{near_x: '0, near_y: '0, near_z: '0, far_x: '0, far_y: '0, far_z: '0,
                 max_distance: npl_pkg::MAX_DIST_RST};
    end else if (wr_en) begin
      unique case (idx)
        npl_pkg::REG_NEAR_X:   cfg_q.near_x       <= wr_coord;
        npl_pkg::REG_NEAR_Y:   cfg_q.near_y       <= wr_coord;
        npl_pkg::REG_NEAR_Z:   cfg_q.near_z       <= wr_coord;
        npl_pkg::REG_FAR_X:    cfg_q.far_x        <= wr_coord;
        npl_pkg::REG_FAR_Y:    cfg_q.far_y        <= wr_coord;
        npl_pkg::REG_FAR_Z:    cfg_q.far_z        <= wr_coord;
        npl_pkg::REG_MAX_DIST: cfg_q.max_distance <= wr_limit;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      npl_pkg::REG_NEAR_X:   prdata = npl_pkg::PDATA_W'(cfg_q.near_x);
      npl_pkg::REG_NEAR_Y:   prdata = npl_pkg::PDATA_W'(cfg_q.near_y);
      npl_pkg::REG_NEAR_Z:   prdata = npl_pkg::PDATA_W'(cfg_q.near_z);
      npl_pkg::REG_FAR_X:    prdata = npl_pkg::PDATA_W'(cfg_q.far_x);
      npl_pkg::REG_FAR_Y:    prdata = npl_pkg::PDATA_W'(cfg_q.far_y);
      npl_pkg::REG_FAR_Z:    prdata = npl_pkg::PDATA_W'(cfg_q.far_z);
      npl_pkg::REG_MAX_DIST: prdata = npl_pkg::PDATA_W'(cfg_q.max_distance);
      default:               prdata = '0;
    endcase
  end

endmodule

>>> rtl/npl_datapath.sv
`timescale 1ns / 1ps
// Datapath: difference vectors, shared multiplier with accumulator, running minimum
// and result registers. Depends on npl_pkg; driven by npl_ctrl.
module npl_datapath #(
  parameter int unsigned MAX_POINTS = npl_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  npl_pkg::line_cfg_t                cfg_i,
  input  logic signed [npl_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [npl_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [npl_pkg::COORD_W-1:0] point_z_i,
  input  logic                              last_point_i,
  input  npl_pkg::dp_cmd_t                  cmd_i,
  output npl_pkg::dp_status_t               status_o,
  output logic                              found_o,
  output logic [npl_pkg::INDEX_W-1:0]       best_index_o,
  output logic                              overflow_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned DW    = npl_pkg::DIFF_W;
  localparam int unsigned MW    = npl_pkg::MUL_W;

  logic signed [DW-1:0] ab_x_q, ab_y_q, ab_z_q;
  logic signed [DW-1:0] ap_x_q, ap_y_q, ap_z_q;
  logic signed [npl_pkg::CROSS_W-1:0] cx_q, cy_q, cz_q;
  logic [npl_pkg::AB2_W-1:0]  ab2_q;
  logic [npl_pkg::LIM2_W-1:0] lim2_q;
  logic signed [MW-1:0]       op_a, op_b;
  logic signed [npl_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [npl_pkg::PROD_W-1:0] acc_d, acc_q;
  npl_pkg::mul_cmd_t          mul_q;
  logic                       last_q;

  logic [CNT_W-1:0]           count_q;
  logic [npl_pkg::SQ_W-1:0]   min_q;
  logic [IDX_W-1:0]           best_q;
  logic                       have_q;
  logic                       ovf_q;

  logic                       in_range;
  logic                       hit;
  logic                       have_n;
  logic                       ovf_n;
  logic [IDX_W-1:0]           best_n;
  logic [IDX_W+npl_pkg::INDEX_W-1:0] best_ext;
  logic [npl_pkg::SQ_W-1:0]   cross_sq;

  logic                       found_q;
  logic [npl_pkg::INDEX_W-1:0] best_out_q;
  logic                       ovf_out_q;

  function automatic logic signed [DW-1:0] diff(input logic signed [npl_pkg::COORD_W-1:0] p,
                                                input logic signed [npl_pkg::COORD_W-1:0] q);
    return $signed({p[npl_pkg::COORD_W-1], p}) - $signed({q[npl_pkg::COORD_W-1], q});
  endfunction

  function automatic logic signed [MW-1:0] sx_diff(input logic signed [DW-1:0] v);
    return {{(MW - DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] sx_cross(
      input logic signed [npl_pkg::CROSS_W-1:0] v);
    return {{(MW - npl_pkg::CROSS_W){v[npl_pkg::CROSS_W-1]}}, v};
  endfunction

  function automatic logic signed [MW-1:0] opnd(input npl_pkg::opnd_e sel,
      input logic signed [DW-1:0] abx, input logic signed [DW-1:0] aby,
      input logic signed [DW-1:0] abz, input logic signed [DW-1:0] apx,
      input logic signed [DW-1:0] apy, input logic signed [DW-1:0] apz,
      input logic [npl_pkg::LIMIT_W-1:0] lim, input logic [npl_pkg::LIM2_W-1:0] lim2,
      input logic [npl_pkg::AB2_W-1:0] ab2, input logic signed [npl_pkg::CROSS_W-1:0] cx,
      input logic signed [npl_pkg::CROSS_W-1:0] cy,
      input logic signed [npl_pkg::CROSS_W-1:0] cz);
    logic signed [MW-1:0] r;
    r = '0;
    unique case (sel)
      npl_pkg::OPND_ABX:  r = sx_diff(abx);
      npl_pkg::OPND_ABY:  r = sx_diff(aby);
      npl_pkg::OPND_ABZ:  r = sx_diff(abz);
      npl_pkg::OPND_APX:  r = sx_diff(apx);
      npl_pkg::OPND_APY:  r = sx_diff(apy);
      npl_pkg::OPND_APZ:  r = sx_diff(apz);
      npl_pkg::OPND_LIM:  r = {{(MW - npl_pkg::LIMIT_W){1'b0}}, lim};
      npl_pkg::OPND_LIM2: r = {{(MW - npl_pkg::LIM2_W){1'b0}}, lim2};
      npl_pkg::OPND_AB2:  r = {{(MW - npl_pkg::AB2_W){1'b0}}, ab2};
      npl_pkg::OPND_CX:   r = sx_cross(cx);
      npl_pkg::OPND_CY:   r = sx_cross(cy);
      npl_pkg::OPND_CZ:   r = sx_cross(cz);
      default:            r = '0;
    endcase
    return r;
  endfunction

  assign op_a = opnd(cmd_i.mul.a, ab_x_q, ab_y_q, ab_z_q, ap_x_q, ap_y_q, ap_z_q,
                     cfg_i.max_distance, lim2_q, ab2_q, cx_q, cy_q, cz_q);
  assign op_b = opnd(cmd_i.mul.b, ab_x_q, ab_y_q, ab_z_q, ap_x_q, ap_y_q, ap_z_q,
                     cfg_i.max_distance, lim2_q, ab2_q, cx_q, cy_q, cz_q);
  assign prod_d = op_a * op_b;

  always_comb begin
    acc_d = acc_q;
    unique case (mul_q.acc)
      npl_pkg::ACC_HOLD: acc_d = acc_q;
      npl_pkg::ACC_LOAD: acc_d = prod_q;
      npl_pkg::ACC_ADD:  acc_d = acc_q + prod_q;
      npl_pkg::ACC_SUB:  acc_d = acc_q - prod_q;
      default:           acc_d = acc_q;
    endcase
  end

  // Capture the point and line vectors on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ab_x_q <= diff(cfg_i.far_x, cfg_i.near_x);
      ab_y_q <= diff(cfg_i.far_y, cfg_i.near_y);
      ab_z_q <= diff(cfg_i.far_z, cfg_i.near_z);
      ap_x_q <= diff(point_x_i, cfg_i.near_x);
      ap_y_q <= diff(point_y_i, cfg_i.near_y);
      ap_z_q <= diff(point_z_i, cfg_i.near_z);
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    unique case (mul_q.dst)
      npl_pkg::DST_CX:   cx_q   <= acc_d[npl_pkg::CROSS_W-1:0];
      npl_pkg::DST_CY:   cy_q   <= acc_d[npl_pkg::CROSS_W-1:0];
      npl_pkg::DST_CZ:   cz_q   <= acc_d[npl_pkg::CROSS_W-1:0];
      npl_pkg::DST_AB2:  ab2_q  <= acc_d[npl_pkg::AB2_W-1:0];
      npl_pkg::DST_LIM2: lim2_q <= acc_d[npl_pkg::LIM2_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= npl_pkg::MUL_NOP;
      last_q <= 1'b0;
    end else begin
      mul_q <= cmd_i.mul;
      if (cmd_i.start) begin
        last_q <= last_point_i;
      end
    end
  end

  assign status_o.last = last_q;

  assign in_range = count_q < CNT_W'(MAX_POINTS);
  assign cross_sq = acc_q[npl_pkg::SQ_W-1:0];
  assign hit      = in_range && (cross_sq < min_q);
  assign have_n   = have_q | hit;
  assign ovf_n    = ovf_q | ~in_range;
  assign best_n   = hit ? count_q[IDX_W-1:0] : best_q;
  assign best_ext = {{npl_pkg::INDEX_W{1'b0}}, best_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      best_q  <= '0;
      have_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.update) begin
      if (last_q) begin
        count_q <= '0;
        min_q   <= '0;
        best_q  <= '0;
        have_q  <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        if (in_range) begin
          count_q <= count_q + CNT_W'(1);
        end
        if (hit) begin
          min_q <= cross_sq;
        end
        best_q <= best_n;
        have_q <= have_n;
        ovf_q  <= ovf_n;
      end
    end else if (mul_q.dst == npl_pkg::DST_MIN && count_q == '0) begin
      // reload the limit at set start
      min_q <= acc_d[npl_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q    <= have_n;
      best_out_q <= have_n ? best_ext[npl_pkg::INDEX_W-1:0] : '0;
      ovf_out_q  <= ovf_n;
    end
  end

  assign found_o      = found_q;
  assign best_index_o = best_out_q;
  assign overflow_o   = ovf_out_q;

endmodule

>>> rtl/npl_ctrl.sv
`timescale 1ns / 1ps
// Controller: handshakes, multiply schedule sequencing and result valid.
// Depends on npl_pkg; drives npl_datapath.
module npl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  npl_pkg::dp_status_t  status_i,
  output npl_pkg::dp_cmd_t     cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [npl_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic                        hold;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hold        = status_i.last && out_valid_q && !out_ready_i;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '{start: 1'b0, update: 1'b0, emit: 1'b0, mul: npl_pkg::MUL_NOP};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == npl_pkg::STEP_DRAIN) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mul = npl_pkg::step_cmd(step_q);
          step_d    = step_q + npl_pkg::STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (!hold) begin
          cmd_o.update = 1'b1;
          cmd_o.emit   = status_i.last;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/nearest_point_to_line_search_top.sv
`timescale 1ns / 1ps
// Nearest point to line search, one point at a time: transfer, 14 shared multiplier steps,
// a drain step, then compare and update, where a set's last point waits while the prior
// result is untaken. The result of a set is valid the cycle after its last point's update.
// Reset (rst_ni low, asynchronous) clears the search state and the output valid and loads
// the registers with their defaults: line end points 0, distance limit 640 (10.0).
module nearest_point_to_line_search_top #(
  parameter int unsigned MAX_POINTS = npl_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [npl_pkg::PADDR_W-1:0]        paddr,
  input  logic [npl_pkg::PDATA_W-1:0]        pwdata,
  output logic [npl_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [npl_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [npl_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [npl_pkg::COORD_W-1:0] point_z_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic [npl_pkg::INDEX_W-1:0]        best_index_o,
  output logic                               overflow_o
);

  npl_pkg::line_cfg_t  cfg;
  npl_pkg::dp_cmd_t    dp_cmd;
  npl_pkg::dp_status_t dp_status;

  npl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  npl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  npl_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .found_o      (found_o),
    .best_index_o (best_index_o),
    .overflow_o   (overflow_o)
  );

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second point taken while one is in flight");

  a_no_find_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> best_index_o == '0)
    else $error("index reported without a qualifying point");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dp_cmd.emit))
    else $error("result valid without a set end");

  a_update_not_with_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.update |-> !dp_cmd.start && dp_cmd.mul.acc == npl_pkg::ACC_HOLD)
    else $error("update overlaps a transfer or a multiply step");
`endif

endmodule

>>> verif/nearest_point_to_line_search_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_point_to_line_search_top: directed table, then random point sets.
// Each set result is predicted from shadow line registers or typed in a row. Depends on npl_pkg.
module nearest_point_to_line_search_top_tb;

  localparam int MAX_PTS       = npl_pkg::MAX_POINTS_DEF;
  localparam int COORD_MAX     = 2 ** (npl_pkg::COORD_W - 1) - 1;
  localparam int COORD_MIN     = -(2 ** (npl_pkg::COORD_W - 1));
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int N_SEGMENTS    = 8;
  localparam int SEG_POINTS    = 242;
  localparam int N_ROWS        = 32;
  localparam logic [npl_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [npl_pkg::COORD_W-1:0] x;
    logic signed [npl_pkg::COORD_W-1:0] y;
    logic signed [npl_pkg::COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                        found;
    logic [npl_pkg::INDEX_W-1:0] index;
    logic                        ovf;
  } search_result_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [npl_pkg::REG_IDX_W-1:0] reg_idx;
    int                            value;
    int                            px;
    int                            py;
    int                            pz;
    bit                            last;
    bit                            typed;
    bit                            found;
    int                            index;
    bit                            ovf;
  } stim_row_t;

  // kind, register, value, x, y, z, last, typed, found, index, overflow
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ROW_POINT, REG_SPARE,             0,         0,     0,     0, 1, 1, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_NEAR_X,   -8192,     0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_NEAR_Y,   -8192,     0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_NEAR_Z,   -8192,     0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_X,    8191,      0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_Y,    8191,      0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_Z,    8191,      0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_MAX_DIST, 8191,      0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,     -8192, -8192, -8192, 1, 1, 1, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,      8191, -8192,  8191, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,     -8192,  8191, -8192, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,      8191,  8191,  8191, 1, 1, 1, 2, 0},
    '{ROW_WRITE, npl_pkg::REG_MAX_DIST, 0,         0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,         0,     0,     0, 1, 1, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_MAX_DIST, 640,       0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, REG_SPARE,             12345,     0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,         0,     0,     1, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,         0,     0,     1, 1, 1, 1, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,       100,   -50,    30, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_X,    0,         0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,     -3000,    20,  4000, 1, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,     -8192,  8191,     0, 1, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,       500,   500,   400, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,        10,    10,    12, 1, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_NEAR_X,   123,       0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_NEAR_Y,   -456,      0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_NEAR_Z,   789,       0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_X,    123,       0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_Y,    -456,      0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, npl_pkg::REG_FAR_Z,    789,       0,     0,     0, 0, 0, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,       123,  -456,   789, 1, 1, 0, 0, 0},
    '{ROW_POINT, REG_SPARE,             0,      8191,  8191,  8191, 1, 1, 0, 0, 0}
  };

  logic                               clk_i;
  logic                               rst_ni;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [npl_pkg::PADDR_W-1:0]        paddr;
  logic [npl_pkg::PDATA_W-1:0]        pwdata;
  logic [npl_pkg::PDATA_W-1:0]        prdata;
  logic                               pready;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [npl_pkg::COORD_W-1:0] point_x_i;
  logic signed [npl_pkg::COORD_W-1:0] point_y_i;
  logic signed [npl_pkg::COORD_W-1:0] point_z_i;
  logic                               last_point_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic                               found_o;
  logic [npl_pkg::INDEX_W-1:0]        best_index_o;
  logic                               overflow_o;

  npl_pkg::line_cfg_t cfg;
  int             pts_seen;
  longint unsigned min_cross;
  int             best_idx;
  bit             have_best;
  bit             set_ovf;
  search_result_t pending_results [$];
  point_t         prev_pt;
  int             idle_pct;
  int             stall_pct;
  int             hold_cycles;
  int             mismatches;
  int             cycle_count;

  nearest_point_to_line_search_top #(
    .MAX_POINTS(MAX_PTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .best_index_o (best_index_o),
    .overflow_o   (overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void track_point(input point_t p, input logic last);
    longint ax, ay, az, abx, aby, abz, apx, apy, apz, cx, cy, cz;
    longint unsigned lim, ab2, c2;
    search_result_t res;
    ax  = longint'($signed(cfg.near_x));
    ay  = longint'($signed(cfg.near_y));
    az  = longint'($signed(cfg.near_z));
    abx = longint'($signed(cfg.far_x)) - ax;
    aby = longint'($signed(cfg.far_y)) - ay;
    abz = longint'($signed(cfg.far_z)) - az;
    if (pts_seen == 0) begin
      lim = cfg.max_distance;
      ab2 = abx * abx + aby * aby + abz * abz;
      min_cross = lim * lim * ab2;
    end
    if (pts_seen < MAX_PTS) begin
      apx = longint'($signed(p.x)) - ax;
      apy = longint'($signed(p.y)) - ay;
      apz = longint'($signed(p.z)) - az;
      cx  = apy * abz - apz * aby;
      cy  = apz * abx - apx * abz;
      cz  = apx * aby - apy * abx;
      c2  = cx * cx + cy * cy + cz * cz;
      if (c2 < min_cross) begin
        min_cross = c2;
        best_idx  = pts_seen;
        have_best = 1'b1;
      end
      pts_seen++;
    end else begin
      set_ovf = 1'b1;
    end
    if (last) begin
      res.found = have_best;
      res.index = have_best ? npl_pkg::INDEX_W'(best_idx) : '0;
      res.ovf   = set_ovf;
      pending_results.push_back(res);
      pts_seen  = 0;
      min_cross = 0;
      best_idx  = 0;
      have_best = 1'b0;
      set_ovf   = 1'b0;
    end
  endfunction

  function automatic point_t draw_point();
    point_t p;
    int a [3];
    int ab [3];
    int v [3];
    int t, r, mode;
    a[0]  = int'($signed(cfg.near_x));
    a[1]  = int'($signed(cfg.near_y));
    a[2]  = int'($signed(cfg.near_z));
    ab[0] = int'($signed(cfg.far_x)) - a[0];
    ab[1] = int'($signed(cfg.far_y)) - a[1];
    ab[2] = int'($signed(cfg.far_z)) - a[2];
    mode  = $urandom_range(99);
    t     = int'($urandom_range(24)) - 4;
    r     = int'(cfg.max_distance) + 2;
    for (int i = 0; i < 3; i++) begin
      if (mode < 60) begin
        v[i] = a[i] + (ab[i] * t) / 16;
        v[i] = v[i] + int'($urandom_range(2 * r)) - r;
      end else if (mode < 85) begin
        v[i] = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
      end else begin
        case ($urandom_range(3))
          0:       v[i] = COORD_MIN;
          1:       v[i] = COORD_MAX;
          2:       v[i] = 0;
          default: v[i] = -1;
        endcase
      end
      if (v[i] > COORD_MAX) v[i] = COORD_MAX;
      else if (v[i] < COORD_MIN) v[i] = COORD_MIN;
    end
    p.x = npl_pkg::COORD_W'(v[0]);
    p.y = npl_pkg::COORD_W'(v[1]);
    p.z = npl_pkg::COORD_W'(v[2]);
    // repeat the previous point now and then: ties go to the earlier one
    if (mode >= 95) p = prev_pt;
    prev_pt = p;
    return p;
  endfunction

  function automatic logic [npl_pkg::PDATA_W-1:0] coord_word(input int v);
    logic [npl_pkg::PDATA_W-1:0] w;
    w = $urandom();
    w[npl_pkg::COORD_W-1:0] = npl_pkg::COORD_W'(v);
    return w;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic apb_write(input logic [npl_pkg::REG_IDX_W-1:0] idx,
                           input logic [npl_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      npl_pkg::REG_NEAR_X:   cfg.near_x       = val[npl_pkg::COORD_W-1:0];
      npl_pkg::REG_NEAR_Y:   cfg.near_y       = val[npl_pkg::COORD_W-1:0];
      npl_pkg::REG_NEAR_Z:   cfg.near_z       = val[npl_pkg::COORD_W-1:0];
      npl_pkg::REG_FAR_X:    cfg.far_x        = val[npl_pkg::COORD_W-1:0];
      npl_pkg::REG_FAR_Y:    cfg.far_y        = val[npl_pkg::COORD_W-1:0];
      npl_pkg::REG_FAR_Z:    cfg.far_z        = val[npl_pkg::COORD_W-1:0];
      npl_pkg::REG_MAX_DIST: cfg.max_distance = val[npl_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_point(input point_t p, input logic last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= p.x;
    point_y_i    <= p.y;
    point_z_i    <= p.z;
    last_point_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_point(p, last);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_random_line();
    int n [3];
    int f [3];
    int kind, lim;
    logic [npl_pkg::PDATA_W-1:0] w;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      n[i] = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
      f[i] = (kind == 0) ? n[i] : int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
      if (kind == 1) begin
        n[i] = $urandom_range(1) ? COORD_MIN : COORD_MAX;
        f[i] = -1 - n[i];
      end
    end
    apb_write(npl_pkg::REG_NEAR_X, coord_word(n[0]));
    apb_write(npl_pkg::REG_NEAR_Y, coord_word(n[1]));
    apb_write(npl_pkg::REG_NEAR_Z, coord_word(n[2]));
    apb_write(npl_pkg::REG_FAR_X, coord_word(f[0]));
    apb_write(npl_pkg::REG_FAR_Y, coord_word(f[1]));
    apb_write(npl_pkg::REG_FAR_Z, coord_word(f[2]));
    kind = $urandom_range(9);
    lim  = (kind == 0) ? 0 : (kind == 1) ? 2 ** npl_pkg::LIMIT_W - 1 : $urandom_range(2000, 1);
    w    = $urandom();
    w[npl_pkg::LIMIT_W-1:0] = npl_pkg::LIMIT_W'(lim);
    apb_write(npl_pkg::REG_MAX_DIST, w);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    search_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: found=%0b index=%0d overflow=%0b",
                                found_o, best_index_o, overflow_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (found_o !== exp_res.found || best_index_o !== exp_res.index ||
            overflow_o !== exp_res.ovf) begin
          note_mismatch($sformatf(
            "result mismatch: expected found=%0b index=%0d overflow=%0b, got %0b %0d %0b",
            exp_res.found, exp_res.index, exp_res.ovf, found_o, best_index_o, overflow_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_point_to_line_search_top regression: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    point_t p;
    search_result_t typed_res;
    int items, sz, r;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    point_x_i    = '0;
    point_y_i    = '0;
    point_z_i    = '0;
    last_point_i = 1'b0;
    out_ready_i  = 1'b0;
    cfg          = '0;
    cfg.max_distance = npl_pkg::MAX_DIST_RST;
    pts_seen     = 0;
    min_cross    = 0;
    best_idx     = 0;
    have_best    = 1'b0;
    set_ovf      = 1'b0;
    prev_pt      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_cycles  = 0;
    mismatches   = 0;
    cycle_count  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        apb_write(row.reg_idx, row.value);
      end else begin
        p.x = npl_pkg::COORD_W'(row.px);
        p.y = npl_pkg::COORD_W'(row.py);
        p.z = npl_pkg::COORD_W'(row.pz);
        push_point(p, row.last);
        if (row.typed) begin
          void'(pending_results.pop_back());
          typed_res.found = row.found;
          typed_res.index = npl_pkg::INDEX_W'(row.index);
          typed_res.ovf   = row.ovf;
          pending_results.push_back(typed_res);
        end
      end
    end

    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      wait_idle();
      case (seg % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      load_random_line();
      if (seg == 4) hold_cycles = 800;
      items = 0;
      while (items < SEG_POINTS) begin
        r  = $urandom_range(99);
        sz = (r < 70) ? $urandom_range(6, 1) : (r < 95) ? $urandom_range(30, 7)
                                                        : $urandom_range(120, 31);
        if (sz > SEG_POINTS - items) sz = SEG_POINTS - items;
        for (int k = 0; k < sz; k++) push_point(draw_point(), k == sz - 1);
        items += sz;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("nearest_point_to_line_search_top regression: pass");
    end else begin
      $display("nearest_point_to_line_search_top regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/npl_pkg.sv
rtl/npl_regs.sv
rtl/npl_datapath.sv
rtl/npl_ctrl.sv
rtl/nearest_point_to_line_search_top.sv
verif/nearest_point_to_line_search_top_tb.sv
